// ----- hw/rtl/ircu_pkg.sv -----
package ircu_pkg;

  localparam int SLOT_W = 9;
  localparam int SLOT_REACH = 512;
  localparam int KZS_W = 23;
  localparam int COORD_W = 31;

  typedef enum logic [1:0] {
    ACT_REQUEST  = 2'd0,
    ACT_COMPLETE = 2'd1,
    ACT_RELEASE  = 2'd2,
    ACT_UNKNOWN  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_OWNER     = 3'd0,
    ST_JOINED    = 3'd1,
    ST_FULL      = 3'd2,
    ST_COMPLETED = 3'd3,
    ST_RELEASED  = 3'd4,
    ST_REJECTED  = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    EX_IDLE,
    EX_READ,
    EX_SCAN,
    EX_SLOT,
    EX_WRITE,
    EX_OUT
  } ex_state_t;

  typedef struct packed {
    logic [1:0]         action;
    logic [1:0]         kind;
    logic [4:0]         zoom;
    logic [COORD_W-1:0] tile_x;
    logic [COORD_W-1:0] tile_y;
    logic [15:0]        tile_size;
    logic [SLOT_W-1:0]  slot_index;
    logic               success;
  } in_word_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [SLOT_W-1:0] slot_out;
    logic              already_done;
    logic              job_ok;
    logic              freed;
  } out_word_t;

  typedef struct packed {
    in_word_t   word;
    logic       slot_ok;
  } cmd_t;

endpackage

// ----- hw/rtl/ircu_if.sv -----
interface ircu_in_if;
  import ircu_pkg::*;
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ircu_out_if;
  import ircu_pkg::*;
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/ircu_front.sv -----
module ircu_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ircu_pkg::in_word_t in_data,
  output logic               q_valid,
  input  logic               q_ready,
  output ircu_pkg::in_word_t q_data
);
  import ircu_pkg::*;

  // two-entry queue between front and back
  in_word_t   buf_r [2];
  logic       wp_r, rp_r, wp_nxt, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_data   = buf_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) buf_r[wp_r] <= in_data;
  end
endmodule

// ----- hw/rtl/ircu_back.sv -----
module ircu_back #(
  parameter int NUM_SLOTS = 512,
  parameter int REF_BITS  = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  output logic                q_ready,
  input  ircu_pkg::in_word_t  q_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ircu_pkg::out_word_t out_data
);
  import ircu_pkg::*;

  localparam int USABLE = (NUM_SLOTS < SLOT_REACH) ? NUM_SLOTS : SLOT_REACH;
  localparam int IDX_W  = (USABLE > 1) ? $clog2(USABLE) : 1;
  localparam int CNT_W  = $clog2(USABLE + 1);
  localparam logic [REF_BITS-1:0] REF_MAX = '1;
  localparam int ENT_W = REF_BITS + KZS_W + 2 * COORD_W;

  // flag bits in flip-flops, reset-cleared; payload in memory
  logic [USABLE-1:0] used_r, done_r, ok_r;
  logic [ENT_W-1:0]  mem [USABLE];
  logic [ENT_W-1:0]  rd_r;

  ex_state_t st_r, st_nxt;
  in_word_t  cmd_r;
  logic [CNT_W-1:0] scan_r, scan_nxt;
  logic [IDX_W-1:0] hit_r, hit_nxt, free_r, free_nxt;
  logic hit_f_r, hit_f_nxt, free_f_r, free_f_nxt;
  out_word_t res_r, res_nxt;
  logic [IDX_W-1:0] rd_addr, wr_addr;
  logic [ENT_W-1:0] wr_data;
  logic             wr_en;
  logic [KZS_W-1:0] key_kzs;
  logic [REF_BITS-1:0] rd_refs, new_refs;
  logic [IDX_W-1:0] scan_idx, sel_idx;
  logic idx_ok;
  logic [USABLE-1:0] used_nxt, done_nxt, ok_nxt;

  assign key_kzs  = {cmd_r.kind, cmd_r.zoom, cmd_r.tile_size};
  assign rd_refs  = rd_r[ENT_W-1 -: REF_BITS];
  assign scan_idx = scan_r[IDX_W-1:0];
  assign idx_ok   = ({{(16-SLOT_W){1'b0}}, cmd_r.slot_index} < 16'(USABLE));
  assign sel_idx  = IDX_W'(cmd_r.slot_index);
  assign q_ready  = (st_r == EX_IDLE);
  assign out_valid = (st_r == EX_OUT);
  assign out_data  = res_r;

  // leave the scan in the cycle of the hit, while rd_r still holds that entry
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      EX_IDLE:  if (q_valid) st_nxt = EX_READ;
      EX_READ:  st_nxt = (cmd_r.action == ACT_REQUEST) ? EX_SCAN : EX_SLOT;
      EX_SCAN:  if (hit_f_nxt || scan_r == CNT_W'(USABLE)) st_nxt = EX_WRITE;
      EX_SLOT:  st_nxt = EX_WRITE;
      EX_WRITE: st_nxt = EX_OUT;
      EX_OUT:   if (out_ready) st_nxt = EX_IDLE;
      default:  st_nxt = EX_IDLE;
    endcase
  end

  // scan: read data is registered behind its address; compare entry scan_r-1
  always_comb begin
    scan_nxt   = scan_r;
    hit_nxt    = hit_r;
    free_nxt   = free_r;
    hit_f_nxt  = hit_f_r;
    free_f_nxt = free_f_r;
    rd_addr    = scan_idx;
    case (st_r)
      EX_READ: begin
        scan_nxt = CNT_W'(1);
        hit_f_nxt = 1'b0;
        free_f_nxt = 1'b0;
        rd_addr = (cmd_r.action == ACT_REQUEST) ? '0 : sel_idx;
      end
      EX_SCAN: begin
        if (!hit_f_r && scan_r != CNT_W'(USABLE)) begin
          scan_nxt = scan_r + 1'b1;
        end
        if (!hit_f_r) begin
          if (used_r[hit_r] && rd_r[ENT_W-REF_BITS-1 -: KZS_W] == key_kzs &&
              rd_r[2*COORD_W-1 -: COORD_W] == cmd_r.tile_x &&
              rd_r[COORD_W-1:0] == cmd_r.tile_y) begin
            hit_f_nxt = 1'b1;
          end else begin
            if (!used_r[hit_r] && !free_f_r) begin
              free_f_nxt = 1'b1;
              free_nxt   = hit_r;
            end
            if (scan_r != CNT_W'(USABLE)) hit_nxt = scan_idx;
          end
        end
      end
      EX_WRITE: rd_addr = hit_r;
      default: ;
    endcase
    if (st_r == EX_READ) hit_nxt = '0;
  end

  always_comb begin
    res_nxt  = res_r;
    wr_en    = 1'b0;
    wr_addr  = hit_r;
    wr_data  = rd_r;
    new_refs = rd_refs + 1'b1;
    used_nxt = used_r;
    done_nxt = done_r;
    ok_nxt   = ok_r;
    case (st_r)
      EX_SCAN: if (st_nxt == EX_WRITE) begin
        if (hit_f_nxt) begin
          if (rd_refs == REF_MAX) begin
            res_nxt = '{ST_FULL, '0, 1'b0, 1'b0, 1'b0};
          end else begin
            wr_en   = 1'b1;
            wr_addr = hit_nxt;
            wr_data = {new_refs, rd_r[ENT_W-REF_BITS-1:0]};
            res_nxt = '{ST_JOINED, SLOT_W'(hit_nxt), done_r[hit_nxt], 1'b0, 1'b0};
          end
        end else if (free_f_nxt) begin
          wr_en   = 1'b1;
          wr_addr = free_nxt;
          wr_data = {REF_BITS'(1), key_kzs, cmd_r.tile_x, cmd_r.tile_y};
          used_nxt[free_nxt] = 1'b1;
          done_nxt[free_nxt] = 1'b0;
          ok_nxt[free_nxt]   = 1'b0;
          res_nxt = '{ST_OWNER, SLOT_W'(free_nxt), 1'b0, 1'b0, 1'b0};
        end else begin
          res_nxt = '{ST_FULL, '0, 1'b0, 1'b0, 1'b0};
        end
      end
      EX_SLOT: begin
        res_nxt = '{ST_REJECTED, '0, 1'b0, 1'b0, 1'b0};
        if (idx_ok && used_r[sel_idx]) begin
          if (cmd_r.action == ACT_COMPLETE && !done_r[sel_idx]) begin
            done_nxt[sel_idx] = 1'b1;
            ok_nxt[sel_idx]   = cmd_r.success;
            res_nxt = '{ST_COMPLETED, cmd_r.slot_index, 1'b0, 1'b0, 1'b0};
          end else if (cmd_r.action == ACT_RELEASE && done_r[sel_idx]) begin
            wr_en   = 1'b1;
            wr_addr = sel_idx;
            new_refs = (rd_refs != '0) ? rd_refs - 1'b1 : rd_refs;
            wr_data = {new_refs, rd_r[ENT_W-REF_BITS-1:0]};
            if (new_refs == '0) used_nxt[sel_idx] = 1'b0;
            res_nxt = '{ST_RELEASED, cmd_r.slot_index, 1'b0, ok_r[sel_idx],
                        new_refs == '0};
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= EX_IDLE;
      used_r <= '0;
      done_r <= '0;
      ok_r   <= '0;
    end else begin
      st_r   <= st_nxt;
      used_r <= used_nxt;
      done_r <= done_nxt;
      ok_r   <= ok_nxt;
    end
    if (st_r == EX_IDLE && q_valid) cmd_r <= q_data;
    scan_r   <= scan_nxt;
    hit_r    <= hit_nxt;
    free_r   <= free_nxt;
    hit_f_r  <= hit_f_nxt;
    free_f_r <= free_f_nxt;
    res_r    <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_r <= mem[rd_addr];
  end
endmodule

// ----- hw/rtl/inflight_request_coalescing_table_unit.sv -----
// From input handshake to result valid: a request that hits slot k waits for the scan to
//   reach slot k, a miss or a full table scans all usable slots (one slot compared per cycle by
//   the single memory read port); completion and release do not scan.
// Throughput: one item at a time; the back takes the next item only after the result is accepted.
// Reset: synchronous active-low rst_n clears the queue, the sequencer and the
//   used/done/ok flags; slot key and count memory is not cleared.
module inflight_request_coalescing_table_unit #(
  parameter int NUM_SLOTS = 512,
  parameter int REF_BITS  = 16
) (
  input logic clk,
  input logic rst_n,
  ircu_in_if.sink    in_ch,
  ircu_out_if.source out_ch
);
  import ircu_pkg::*;

  logic     q_valid, q_ready;
  in_word_t q_data;

  ircu_front u_front (
    .clk, .rst_n,
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_data  (in_ch.data),
    .q_valid, .q_ready, .q_data
  );

  ircu_back #(.NUM_SLOTS(NUM_SLOTS), .REF_BITS(REF_BITS)) u_back (
    .clk, .rst_n,
    .q_valid, .q_ready, .q_data,
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_ch.data)
  );

  a_one_flight: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !q_ready) else $error("back busy flag lost");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
    else $error("result dropped");
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.data.status <= ST_REJECTED) else $error("bad status");
endmodule

// ----- test/testbench.sv -----
`default_nettype none

module testbench;
  import ircu_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_SLOTS = 512;
  localparam int REF_LIMIT = 65535;

  logic clk;
  logic rst_n;

  ircu_in_if  in_ch ();
  ircu_out_if out_ch ();

  inflight_request_coalescing_table_unit dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // shadow of the table, advanced in word order
  bit                 tbl_used [TABLE_SLOTS];
  bit                 tbl_done [TABLE_SLOTS];
  bit                 tbl_ok   [TABLE_SLOTS];
  int unsigned        tbl_refs [TABLE_SLOTS];
  logic [1:0]         tbl_kind [TABLE_SLOTS];
  logic [4:0]         tbl_zoom [TABLE_SLOTS];
  logic [15:0]        tbl_size [TABLE_SLOTS];
  logic [COORD_W-1:0] tbl_col  [TABLE_SLOTS];
  logic [COORD_W-1:0] tbl_row  [TABLE_SLOTS];

  in_word_t  request_q [$];
  out_word_t outcome_q [$];
  int        errors;
  int        n_checked;
  bit        no_idle;

  function automatic out_word_t mk_out(status_t st, int slot, bit ad, bit ok, bit fr);
    out_word_t o;
    o.status = st;
    o.slot_out = slot[SLOT_W-1:0];
    o.already_done = ad;
    o.job_ok = ok;
    o.freed = fr;
    return o;
  endfunction

  function automatic out_word_t table_step(in_word_t w);
    int s;
    if (w.action == ACT_REQUEST) begin
      for (int i = 0; i < TABLE_SLOTS; i++) begin
        if (tbl_used[i] && tbl_kind[i] == w.kind && tbl_zoom[i] == w.zoom &&
            tbl_size[i] == w.tile_size && tbl_col[i] == w.tile_x && tbl_row[i] == w.tile_y) begin
          if (tbl_refs[i] >= REF_LIMIT) return mk_out(ST_FULL, 0, 0, 0, 0);
          tbl_refs[i]++;
          return mk_out(ST_JOINED, i, tbl_done[i], 0, 0);
        end
      end
      for (int i = 0; i < TABLE_SLOTS; i++) begin
        if (!tbl_used[i]) begin
          tbl_used[i] = 1;
          tbl_done[i] = 0;
          tbl_ok[i] = 0;
          tbl_refs[i] = 1;
          tbl_kind[i] = w.kind;
          tbl_zoom[i] = w.zoom;
          tbl_size[i] = w.tile_size;
          tbl_col[i] = w.tile_x;
          tbl_row[i] = w.tile_y;
          return mk_out(ST_OWNER, i, 0, 0, 0);
        end
      end
      return mk_out(ST_FULL, 0, 0, 0, 0);
    end
    s = int'(w.slot_index);
    if (w.action == ACT_UNKNOWN || !tbl_used[s]) return mk_out(ST_REJECTED, 0, 0, 0, 0);
    if (w.action == ACT_COMPLETE) begin
      if (tbl_done[s]) return mk_out(ST_REJECTED, 0, 0, 0, 0);
      tbl_done[s] = 1;
      tbl_ok[s] = w.success;
      return mk_out(ST_COMPLETED, s, 0, 0, 0);
    end
    if (!tbl_done[s]) return mk_out(ST_REJECTED, 0, 0, 0, 0);
    if (tbl_refs[s] > 0) tbl_refs[s]--;
    if (tbl_refs[s] == 0) begin
      tbl_used[s] = 0;
      return mk_out(ST_RELEASED, s, 0, tbl_ok[s], 1);
    end
    return mk_out(ST_RELEASED, s, 0, tbl_ok[s], 0);
  endfunction

  function automatic in_word_t key_word(logic [1:0] k, logic [4:0] z, logic [30:0] x,
                                        logic [30:0] y, logic [15:0] sz);
    in_word_t w;
    w.action = ACT_REQUEST;
    w.kind = k;
    w.zoom = z;
    w.tile_x = x;
    w.tile_y = y;
    w.tile_size = sz;
    w.slot_index = SLOT_W'($urandom());
    w.success = 1'($urandom());
    return w;
  endfunction

  function automatic in_word_t slot_word(action_t a, int idx, bit ok);
    in_word_t w;
    w.action = a;
    w.kind = 2'($urandom());
    w.zoom = 5'($urandom());
    w.tile_x = COORD_W'($urandom());
    w.tile_y = COORD_W'($urandom());
    w.tile_size = 16'($urandom());
    w.slot_index = idx[SLOT_W-1:0];
    w.success = ok;
    return w;
  endfunction

  task automatic push_word(in_word_t w);
    outcome_q.push_back(table_step(w));
    request_q.push_back(w);
  endtask

  task automatic wait_drained();
    while (request_q.size() != 0 || outcome_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #200ms;
    $display("RESULT: ERROR");
    $finish;
  end

  // sender: bursts and gaps, holds the word until taken
  bit took;
  int burst_left;
  int gap_left;

  always @(posedge clk) took <= in_ch.valid && in_ch.ready;

  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 0;
      burst_left <= 0;
      gap_left <= 0;
    end else if (!(in_ch.valid && !took)) begin
      if (gap_left > 0 && !no_idle) begin
        gap_left <= gap_left - 1;
        in_ch.valid <= 0;
      end else if (request_q.size() != 0) begin
        in_ch.data <= request_q.pop_front();
        in_ch.valid <= 1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(12, 1);
          gap_left <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_ch.valid <= 0;
      end
    end
  end

  // receiver: runs of ready and stall of random length
  int run_left;
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 0;
      run_left <= 0;
    end else if (run_left > 0) begin
      run_left <= run_left - 1;
    end else if (no_idle || !out_ch.ready) begin
      out_ch.ready <= 1;
      run_left <= $urandom_range(20, 0);
    end else begin
      out_ch.ready <= 0;
      run_left <= ($urandom_range(9, 0) == 0) ? $urandom_range(30, 5) : $urandom_range(3, 0);
    end
  end

  always @(posedge clk) begin
    out_word_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (outcome_q.size() == 0) begin
        $error("unexpected result word status=%0d slot=%0d", out_ch.data.status,
               out_ch.data.slot_out);
        errors++;
      end else begin
        e = outcome_q.pop_front();
        n_checked++;
        if (out_ch.data.status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, out_ch.data.status);
          errors++;
        end
        if (out_ch.data.slot_out !== e.slot_out) begin
          $error("slot_out: expected %0d, got %0d", e.slot_out, out_ch.data.slot_out);
          errors++;
        end
        if (out_ch.data.already_done !== e.already_done) begin
          $error("already_done: expected %0d, got %0d", e.already_done,
                 out_ch.data.already_done);
          errors++;
        end
        if (out_ch.data.job_ok !== e.job_ok) begin
          $error("job_ok: expected %0d, got %0d", e.job_ok, out_ch.data.job_ok);
          errors++;
        end
        if (out_ch.data.freed !== e.freed) begin
          $error("freed: expected %0d, got %0d", e.freed, out_ch.data.freed);
          errors++;
        end
      end
    end
  end

  initial begin
    int used_list [$];
    int pick;
    int r;
    in_word_t pool [8];
    errors = 0;
    n_checked = 0;
    no_idle = 0;
    in_ch.valid = 0;
    in_ch.data = '0;
    out_ch.ready = 0;
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      tbl_used[i] = 0;
      tbl_done[i] = 0;
      tbl_ok[i] = 0;
    end
    rst_n = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1;

    // directed: extreme keys, join, bad completions and releases, unknown action
    push_word(key_word(2'd3, 5'd31, 31'h7fffffff, 31'h7fffffff, 16'hffff));
    push_word(key_word(2'd0, 5'd0, 31'd0, 31'd0, 16'd0));
    push_word(key_word(2'd3, 5'd31, 31'h7fffffff, 31'h7fffffff, 16'hffff));
    push_word(key_word(2'd3, 5'd31, 31'h7fffffff, 31'h7ffffffe, 16'hffff));
    push_word(slot_word(ACT_COMPLETE, 511, 1));
    push_word(slot_word(ACT_RELEASE, 511, 0));
    push_word(slot_word(ACT_RELEASE, 0, 0));
    push_word(slot_word(ACT_COMPLETE, 0, 1));
    push_word(slot_word(ACT_COMPLETE, 0, 0));
    push_word(key_word(2'd3, 5'd31, 31'h7fffffff, 31'h7fffffff, 16'hffff));
    push_word(slot_word(ACT_RELEASE, 0, 0));
    push_word(slot_word(ACT_RELEASE, 0, 0));
    push_word(slot_word(ACT_RELEASE, 0, 0));
    push_word(slot_word(ACT_RELEASE, 0, 0));
    push_word(slot_word(ACT_COMPLETE, 1, 0));
    push_word(slot_word(ACT_RELEASE, 1, 0));
    push_word(slot_word(ACT_UNKNOWN, 2, 1));
    push_word(slot_word(ACT_COMPLETE, 2, 0));
    push_word(slot_word(ACT_RELEASE, 2, 1));
    push_word(key_word(2'd1, 5'd7, 31'h2aaaaaaa, 31'h55555555, 16'h5a5a));
    // hold off until the table has answered everything
    wait_drained();

    // fill every slot and overflow once
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      if (!tbl_used[i])
        push_word(key_word(2'($urandom()), 5'($urandom()), 31'(i), 31'($urandom()),
                           16'($urandom())));
    end
    push_word(key_word(2'd2, 5'd9, 31'h7fffffff, 31'h1234, 16'h1));
    wait_drained();

    // free the low slots with words back to back
    no_idle = 1;
    for (int i = 0; i < 128; i++) begin
      if (!tbl_done[i]) push_word(slot_word(ACT_COMPLETE, i, 1'($urandom())));
      while (tbl_used[i]) push_word(slot_word(ACT_RELEASE, i, 1'($urandom())));
      if (request_q.size() > 16) wait (request_q.size() < 8);
    end
    wait_drained();
    no_idle = 0;

    // random: mostly well-formed lifecycles over a small key pool, some noise
    for (int i = 0; i < 8; i++)
      pool[i] = key_word(2'($urandom()), 5'($urandom()), 31'($urandom()),
                         31'($urandom()), 16'($urandom()));
    for (int n = 0; n < 350; n++) begin
      r = $urandom_range(99, 0);
      used_list.delete();
      for (int i = 0; i < TABLE_SLOTS; i++) if (tbl_used[i]) used_list.push_back(i);
      if (r < 35 || used_list.size() == 0) begin
        if ($urandom_range(4, 0) == 0)
          push_word(key_word(2'($urandom()), 5'($urandom()), 31'($urandom()),
                             31'($urandom()), 16'($urandom())));
        else
          push_word(key_word(pool[$urandom_range(7, 0)].kind, pool[$urandom_range(7, 0)].zoom,
                             pool[$urandom_range(7, 0)].tile_x, pool[0].tile_y,
                             pool[0].tile_size));
      end else if (r < 92) begin
        pick = used_list[$urandom_range(used_list.size() - 1, 0)];
        if (!tbl_done[pick]) push_word(slot_word(ACT_COMPLETE, pick, 1'($urandom())));
        else push_word(slot_word(ACT_RELEASE, pick, 1'($urandom())));
      end else begin
        push_word(slot_word(action_t'($urandom_range(3, 1)), int'($urandom_range(511, 0)),
                            1'($urandom())));
      end
      if (request_q.size() > 16) wait (request_q.size() < 8);
    end

    wait_drained();
    repeat (50) @(posedge clk);
    $display("Checked %0d result words: directed cases, full table, back-to-back frees,",
             n_checked);
    $display("and random request/complete/release traffic with stalls on both sides.");
    if (errors == 0 && outcome_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- inflight_request_coalescing_table_unit.f -----
hw/rtl/ircu_pkg.sv
hw/rtl/ircu_if.sv
hw/rtl/ircu_front.sv
hw/rtl/ircu_back.sv
hw/rtl/inflight_request_coalescing_table_unit.sv
test/testbench.sv
